/* sv/white_rectangle_finder_assert.svh */
// Assertion macros shared by the white rectangle finder RTL.
`ifndef WHITE_RECTANGLE_FINDER_ASSERT_SVH
`define WHITE_RECTANGLE_FINDER_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define WRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Condition must never hold.
`define WRF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

/* sv/wrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White rectangle finder package
// Sizes, event and table entry types, and the run overlap test.
// ----------------------------------------------------------------------------
package wrf_pkg;

   localparam int CAND_DEPTH = 256;
   localparam int CAND_AW    = $clog2(CAND_DEPTH);
   localparam int CAND_CW    = $clog2(CAND_DEPTH + 1);
   localparam int REJ_DEPTH  = 1024;
   localparam int REJ_AW     = $clog2(REJ_DEPTH);
   localparam int REJ_CW     = $clog2(REJ_DEPTH + 1);
   localparam int MAX_DIM    = 4096;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int AREA_W     = 25;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = $clog2(Q_DEPTH);
   localparam int Q_CW       = $clog2(Q_DEPTH + 1);
   localparam int CSR_IDX_W  = 2;

   localparam logic [AREA_W-1:0]    AREA_MAX   = '1;
   localparam logic [7:0]           WHITE_BYTE = 8'hff;
   localparam logic [DIM_W-1:0]     WIDTH_RST  = DIM_W'(640);
   localparam logic [DIM_W-1:0]     HEIGHT_RST = DIM_W'(480);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic               run_valid;
      logic               frame_end;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] row;
   } event_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] first_row;
      logic [COORD_W-1:0] last_row;
      logic [AREA_W-1:0]  area;
   } cand_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] row;
   } rej_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic touches(input logic [COORD_W-1:0] el, input logic [COORD_W-1:0] er,
                                    input logic [COORD_W-1:0] l, input logic [COORD_W-1:0] r);
      return ((el >= l) && (el <= r)) || ((el <= l) && (er >= l));
   endfunction

endpackage

/* sv/wrf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White rectangle finder front end
// Takes pixels, tracks column, row and run state, and queues run end and
// frame end events. Holds the frame size registers.
// ----------------------------------------------------------------------------
module wrf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_byte_first,
   input  logic [7:0]                     req_byte_second,
   input  logic [7:0]                     req_byte_third,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrf_pkg::DIM_W-1:0]      csr_wdata,
   input  wrf_pkg::q_status_type          q_status,
   output logic                           ev_push,
   output wrf_pkg::event_type             ev_data
);

   logic [wrf_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic                        in_run_ff, in_run_in;
   logic [wrf_pkg::COORD_W-1:0] run_start_ff, run_start_in;
   logic [wrf_pkg::COORD_W-1:0] col_ff, col_in;
   logic [wrf_pkg::COORD_W-1:0] row_ff, row_in;
   logic [wrf_pkg::DIM_W-1:0]   w_eff, h_eff;
   logic                        accept, white, last_col, last_row;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = wrf_pkg::DIM_W'(1);
      end else if (width_ff > wrf_pkg::DIM_W'(wrf_pkg::MAX_DIM)) begin
         w_eff = wrf_pkg::DIM_W'(wrf_pkg::MAX_DIM);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = wrf_pkg::DIM_W'(1);
      end else if (height_ff > wrf_pkg::DIM_W'(wrf_pkg::MAX_DIM)) begin
         h_eff = wrf_pkg::DIM_W'(wrf_pkg::MAX_DIM);
      end else begin
         h_eff = height_ff;
      end
   end

   assign last_col = {1'b0, col_ff} >= (w_eff - wrf_pkg::DIM_W'(1));
   assign last_row = {1'b0, row_ff} >= (h_eff - wrf_pkg::DIM_W'(1));
   assign white    = (req_byte_first == wrf_pkg::WHITE_BYTE) &&
                     (req_byte_second == wrf_pkg::WHITE_BYTE) &&
                     (req_byte_third == wrf_pkg::WHITE_BYTE);

   always_comb begin
      ev_data           = '0;
      ev_data.row       = row_ff;
      ev_data.frame_end = last_col && last_row;
      in_run_in         = in_run_ff;
      run_start_in      = run_start_ff;
      if (!white) begin
         if (in_run_ff) begin
            ev_data.run_valid = 1'b1;
            ev_data.left      = run_start_ff;
            ev_data.right     = col_ff - wrf_pkg::COORD_W'(1);
         end
         in_run_in = 1'b0;
      end else begin
         if (!in_run_ff) begin
            run_start_in = col_ff;
            in_run_in    = 1'b1;
         end
         if (last_col) begin
            ev_data.run_valid = 1'b1;
            ev_data.left      = in_run_ff ? run_start_ff : col_ff;
            ev_data.right     = col_ff;
            in_run_in         = 1'b0;
         end
      end
      ev_push = accept && (ev_data.run_valid || ev_data.frame_end);
      col_in  = last_col ? '0 : col_ff + wrf_pkg::COORD_W'(1);
      if (!last_col) begin
         row_in = row_ff;
      end else if (last_row) begin
         row_in = '0;
      end else begin
         row_in = row_ff + wrf_pkg::COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= wrf_pkg::WIDTH_RST;
         height_ff    <= wrf_pkg::HEIGHT_RST;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wrf_pkg::CSR_WIDTH: width_ff <= csr_wdata;
               wrf_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            in_run_ff    <= in_run_in;
            run_start_ff <= run_start_in;
            col_ff       <= col_in;
            row_ff       <= row_in;
         end
      end
   end

endmodule

/* sv/wrf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White rectangle finder event queue
// Small FIFO of run end and frame end events between front and back.
// ----------------------------------------------------------------------------
module wrf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wrf_pkg::event_type    push_data,
   input  logic                  pop,
   output wrf_pkg::event_type    head,
   output wrf_pkg::q_status_type status
);

   wrf_pkg::event_type       mem_ff [wrf_pkg::Q_DEPTH];
   logic [wrf_pkg::Q_AW-1:0] wp_ff, rp_ff;
   logic [wrf_pkg::Q_CW-1:0] cnt_ff;
   logic                     do_push, do_pop;

   assign status.full  = cnt_ff == wrf_pkg::Q_CW'(wrf_pkg::Q_DEPTH);
   assign status.empty = cnt_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= wp_ff + wrf_pkg::Q_AW'(1);
         end
         if (do_pop) begin
            rp_ff <= rp_ff + wrf_pkg::Q_AW'(1);
         end
         case ({do_push, do_pop})
            2'b10: cnt_ff <= cnt_ff + wrf_pkg::Q_CW'(1);
            2'b01: cnt_ff <= cnt_ff - wrf_pkg::Q_CW'(1);
            default: ;
         endcase
      end
   end

endmodule

/* sv/wrf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White rectangle finder back end
// Per run, walks candidates and, if none was touched, the rejected table;
// compacts removed ones in one pass; picks the largest candidate at frame end.
// ----------------------------------------------------------------------------
module wrf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  wrf_pkg::event_type              ev_head,
   input  wrf_pkg::q_status_type           q_status,
   output logic                            ev_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [wrf_pkg::COORD_W-1:0]     rsp_left_col,
   output logic [wrf_pkg::COORD_W-1:0]     rsp_right_col,
   output logic [wrf_pkg::COORD_W-1:0]     rsp_first_row,
   output logic [wrf_pkg::COORD_W-1:0]     rsp_last_row,
   output logic [wrf_pkg::AREA_W-1:0]      rsp_area,
   output logic                            rsp_overflow
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CAND, ST_REJ, ST_PUSH, ST_MAX, ST_EMIT
   } state_type;

   wrf_pkg::cand_type cand_mem [wrf_pkg::CAND_DEPTH];
   wrf_pkg::rej_type  rej_mem [wrf_pkg::REJ_DEPTH];

   state_type                     state_ff, state_in;
   logic [wrf_pkg::REJ_CW-1:0]    rd_ff, rd_in;
   logic [wrf_pkg::CAND_CW-1:0]   wr_ff, wr_in;
   logic                          pend_ff, pend_in;
   logic                          touched_ff, touched_in;
   logic                          blocked_ff, blocked_in;
   logic [wrf_pkg::CAND_CW-1:0]   cand_cnt_ff, cand_cnt_in;
   logic [wrf_pkg::REJ_CW-1:0]    rej_cnt_ff, rej_cnt_in;
   logic                          ovf_ff, ovf_in;
   wrf_pkg::cand_type             best_ff, best_in;
   logic                          has_best_ff, has_best_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   wrf_pkg::cand_type             rsp_ff, rsp_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic                          cand_we, rej_we;
   logic [wrf_pkg::CAND_AW-1:0]   cand_waddr, cand_raddr;
   logic [wrf_pkg::REJ_AW-1:0]    rej_waddr, rej_raddr;
   wrf_pkg::cand_type             cand_wdata, cand_rdata_ff;
   wrf_pkg::rej_type              rej_wdata, rej_rdata_ff;

   logic [wrf_pkg::COORD_W-1:0]   prev_row;
   logic [wrf_pkg::DIM_W-1:0]     run_area;
   logic                          row_nonzero;

   assign prev_row    = ev_head.row - wrf_pkg::COORD_W'(1);
   assign row_nonzero = ev_head.row != '0;
   assign run_area    = {1'b0, ev_head.right} - {1'b0, ev_head.left} + wrf_pkg::DIM_W'(1);

   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_mem[cand_waddr] <= cand_wdata;
      end
      cand_rdata_ff <= cand_mem[cand_raddr];
   end

   always_ff @(posedge clock) begin
      if (rej_we) begin
         rej_mem[rej_waddr] <= rej_wdata;
      end
      rej_rdata_ff <= rej_mem[rej_raddr];
   end

   always_comb begin
      logic                        prev, grow, remove, cand_more, rej_more, slot_free;
      logic [wrf_pkg::AREA_W:0]    sum;
      wrf_pkg::cand_type           e;
      state_in     = state_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pend_in      = pend_ff;
      touched_in   = touched_ff;
      blocked_in   = blocked_ff;
      cand_cnt_in  = cand_cnt_ff;
      rej_cnt_in   = rej_cnt_ff;
      ovf_in       = ovf_ff;
      best_in      = best_ff;
      has_best_in  = has_best_ff;
      rsp_in       = rsp_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ev_pop       = 1'b0;
      cand_we      = 1'b0;
      cand_waddr   = wr_ff[wrf_pkg::CAND_AW-1:0];
      cand_wdata   = cand_rdata_ff;
      cand_raddr   = rd_ff[wrf_pkg::CAND_AW-1:0];
      rej_we       = 1'b0;
      rej_waddr    = rej_cnt_ff[wrf_pkg::REJ_AW-1:0];
      rej_wdata    = '{left: ev_head.left, right: ev_head.right, row: ev_head.row};
      rej_raddr    = rd_ff[wrf_pkg::REJ_AW-1:0];
      e            = cand_rdata_ff;
      cand_more    = rd_ff < wrf_pkg::REJ_CW'(cand_cnt_ff);
      rej_more     = rd_ff < rej_cnt_ff;
      slot_free    = !rsp_valid_ff || !rsp_stall;
      prev         = row_nonzero && (e.last_row == prev_row);
      grow         = prev && (e.left == ev_head.left) && (e.right == ev_head.right);
      remove       = !grow && prev && wrf_pkg::touches(e.left, e.right,
                                                       ev_head.left, ev_head.right);
      sum          = {1'b0, e.area} + (wrf_pkg::AREA_W + 1)'(run_area);

      case (state_ff)
         ST_IDLE: begin
            rd_in       = '0;
            wr_in       = '0;
            pend_in     = 1'b0;
            touched_in  = 1'b0;
            blocked_in  = 1'b0;
            has_best_in = 1'b0;
            if (!q_status.empty) begin
               state_in = ev_head.run_valid ? ST_CAND : ST_MAX;
            end
         end
         ST_CAND: begin
            // stream reads one ahead; writes land at or below the entry in hand
            pend_in = cand_more;
            if (cand_more) begin
               rd_in = rd_ff + wrf_pkg::REJ_CW'(1);
            end
            if (pend_ff) begin
               touched_in = touched_ff || grow || remove;
               if (grow) begin
                  cand_wdata.last_row = ev_head.row;
                  cand_wdata.area     = sum > {1'b0, wrf_pkg::AREA_MAX} ?
                                        wrf_pkg::AREA_MAX : sum[wrf_pkg::AREA_W-1:0];
               end
               if (!remove) begin
                  cand_we = 1'b1;
                  wr_in   = wr_ff + wrf_pkg::CAND_CW'(1);
               end
            end
            if (!pend_ff && !cand_more) begin
               cand_cnt_in = wr_ff;
               rd_in       = '0;
               state_in    = touched_ff ? ST_PUSH : ST_REJ;
            end
         end
         ST_REJ: begin
            pend_in = rej_more;
            if (rej_more) begin
               rd_in = rd_ff + wrf_pkg::REJ_CW'(1);
            end
            if (pend_ff && row_nonzero && (rej_rdata_ff.row == prev_row) &&
                wrf_pkg::touches(rej_rdata_ff.left, rej_rdata_ff.right,
                                 ev_head.left, ev_head.right)) begin
               blocked_in = 1'b1;
            end
            if (!pend_ff && !rej_more) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (touched_ff || blocked_ff) begin
               if (rej_cnt_ff == wrf_pkg::REJ_CW'(wrf_pkg::REJ_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  rej_we     = 1'b1;
                  rej_cnt_in = rej_cnt_ff + wrf_pkg::REJ_CW'(1);
               end
            end else begin
               if (cand_cnt_ff == wrf_pkg::CAND_CW'(wrf_pkg::CAND_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  cand_we     = 1'b1;
                  cand_waddr  = cand_cnt_ff[wrf_pkg::CAND_AW-1:0];
                  cand_wdata  = '{left: ev_head.left, right: ev_head.right,
                                  first_row: ev_head.row, last_row: ev_head.row,
                                  area: wrf_pkg::AREA_W'(run_area)};
                  cand_cnt_in = cand_cnt_ff + wrf_pkg::CAND_CW'(1);
               end
            end
            rd_in       = '0;
            pend_in     = 1'b0;
            has_best_in = 1'b0;
            if (ev_head.frame_end) begin
               state_in = ST_MAX;
            end else begin
               ev_pop   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MAX: begin
            pend_in = cand_more;
            if (cand_more) begin
               rd_in = rd_ff + wrf_pkg::REJ_CW'(1);
            end
            // strict compare keeps the earliest entry on a tie
            if (pend_ff && (!has_best_ff || (e.area > best_ff.area))) begin
               best_in     = e;
               has_best_in = 1'b1;
            end
            if (!pend_ff && !cand_more) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = has_best_ff;
               rsp_in       = has_best_ff ? best_ff : '0;
               rsp_ovf_in   = ovf_ff;
               cand_cnt_in  = '0;
               rej_cnt_in   = '0;
               ovf_in       = 1'b0;
               ev_pop       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         touched_ff   <= 1'b0;
         blocked_ff   <= 1'b0;
         cand_cnt_ff  <= '0;
         rej_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         has_best_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         touched_ff   <= touched_in;
         blocked_ff   <= blocked_in;
         cand_cnt_ff  <= cand_cnt_in;
         rej_cnt_ff   <= rej_cnt_in;
         ovf_ff       <= ovf_in;
         has_best_ff  <= has_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_ff      <= best_in;
      rsp_ff       <= rsp_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_left_col  = rsp_ff.left;
   assign rsp_right_col = rsp_ff.right;
   assign rsp_first_row = rsp_ff.first_row;
   assign rsp_last_row  = rsp_ff.last_row;
   assign rsp_area      = rsp_ff.area;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

/* sv/white_rectangle_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White rectangle finder
// Finds the largest all-white rectangle built from stacked identical runs.
// ----------------------------------------------------------------------------
// A pixel is taken whenever the queue is not full; runs and frame ends enter a 4-entry queue.
// For a run end the back end walks the candidate table and, if no candidate was touched,
// the rejected table, through table memories with registered reads.
// At frame end it seeks the largest candidate; the result then sits in an output register.
// Synchronous reset empties the queue and tables; width/height return to 640x480.
module white_rectangle_finder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_byte_first,
   input  logic [7:0]                     req_byte_second,
   input  logic [7:0]                     req_byte_third,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [wrf_pkg::COORD_W-1:0]    rsp_left_col,
   output logic [wrf_pkg::COORD_W-1:0]    rsp_right_col,
   output logic [wrf_pkg::COORD_W-1:0]    rsp_first_row,
   output logic [wrf_pkg::COORD_W-1:0]    rsp_last_row,
   output logic [wrf_pkg::AREA_W-1:0]     rsp_area,
   output logic                           rsp_overflow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrf_pkg::DIM_W-1:0]      csr_wdata
);

`include "white_rectangle_finder_assert.svh"

   wrf_pkg::q_status_type q_status;
   wrf_pkg::event_type    ev_data, ev_head;
   logic                  ev_push, ev_pop;

   wrf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_first  (req_byte_first),
      .req_byte_second (req_byte_second),
      .req_byte_third  (req_byte_third),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .ev_push         (ev_push),
      .ev_data         (ev_data)
   );

   wrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .pop       (ev_pop),
      .head      (ev_head),
      .status    (q_status)
   );

   wrf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .ev_head       (ev_head),
      .q_status      (q_status),
      .ev_pop        (ev_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_left_col  (rsp_left_col),
      .rsp_right_col (rsp_right_col),
      .rsp_first_row (rsp_first_row),
      .rsp_last_row  (rsp_last_row),
      .rsp_area      (rsp_area),
      .rsp_overflow  (rsp_overflow)
   );

   `WRF_ASSERT_NEVER(a_queue_full_empty, clock, reset, q_status.full && q_status.empty, "queue full and empty")
   `WRF_ASSERT_IMPLY(a_result_from_event, clock, reset, $rose(rsp_valid), $past(!q_status.empty), "result without queued frame end")
   `WRF_ASSERT_IMPLY(a_empty_result_zero, clock, reset, rsp_valid && !rsp_found, (rsp_area == '0) && (rsp_left_col == '0), "no-candidate result not zeroed")

endmodule
